/* rtl/slt_pkg.sv */
// Shared types, constants and keyword tables of the specification language tokenizer.
package slt_pkg;

    // Longest token length that is reported; longer tokens saturate at LEN_CAP.
    localparam int unsigned TOKEN_LENGTH_MAX = 65535;
    localparam int unsigned LEN_CAP_INT =
        (TOKEN_LENGTH_MAX < 65535) ? TOKEN_LENGTH_MAX : 65535;
    localparam logic [15:0] LEN_CAP = 16'(LEN_CAP_INT);

    // Number of result slots in the output queue.
    localparam int unsigned QUEUE_DEPTH = 3;

    // Token kinds.
    localparam logic [3:0] KIND_INVALID = 4'd0;
    localparam logic [3:0] KIND_STRUCT  = 4'd1;
    localparam logic [3:0] KIND_ENUM    = 4'd2;
    localparam logic [3:0] KIND_FLAGS   = 4'd3;
    localparam logic [3:0] KIND_INT     = 4'd4;
    localparam logic [3:0] KIND_IDENT   = 4'd5;
    localparam logic [3:0] KIND_NUMBER  = 4'd6;
    localparam logic [3:0] KIND_STRING  = 4'd7;
    localparam logic [3:0] KIND_SYMBOL  = 4'd8;
    localparam logic [3:0] KIND_END     = 4'd9;

    // Keyword spellings, lengths and kinds: enum, flags, struct.
    localparam logic [7:0] KW_CHARS [3][6] = '{
        '{8'h65, 8'h6E, 8'h75, 8'h6D, 8'h00, 8'h00},
        '{8'h66, 8'h6C, 8'h61, 8'h67, 8'h73, 8'h00},
        '{8'h73, 8'h74, 8'h72, 8'h75, 8'h63, 8'h74}
    };
    localparam logic [2:0] KW_LEN [3] = '{3'd4, 3'd5, 3'd6};
    localparam logic [3:0] KW_KIND [3] = '{KIND_ENUM, KIND_FLAGS, KIND_STRUCT};

    // One token record.
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] start;
        logic [15:0] length;
        logic [5:0]  bits;
        logic        unclosed;
        logic        last;
    } rec_t;

    // Records produced by one accepted transaction, first record first.
    typedef struct packed {
        logic [1:0] count;
        rec_t       first;
        rec_t       second;
    } push_t;

endpackage

/* rtl/slt_scan.sv */
// Scanner state and per-byte token logic of the tokenizer.
module slt_scan
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          character,
    input  logic                end_of_input,
    output slt_pkg::push_t      push
);

    // Scanner modes.
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_SLASH  = 3'd1;
    localparam logic [2:0] MODE_WORD   = 3'd2;
    localparam logic [2:0] MODE_LINE   = 3'd3;
    localparam logic [2:0] MODE_BLOCK  = 3'd4;
    localparam logic [2:0] MODE_STAR   = 3'd5;
    localparam logic [2:0] MODE_STRING = 3'd6;

    // Character codes.
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_S  = 8'h73;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // Word being collected: length, first three bytes, keyword matches and class flags.
    // Flag bit 0 is identifier valid, bit 1 number valid, bit 2 dot seen.
    typedef struct packed {
        logic [15:0] len;
        logic [23:0] lead;
        logic [2:0]  alive;
        logic [2:0]  flags;
    } word_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [5:0] bits;
    } class_t;

    localparam word_t WORD_INIT = '{len: 16'd0, lead: 24'd0, alive: 3'b111, flags: 3'b011};

    logic [2:0]  mode_reg, mode_next;
    logic        quote_dbl_reg, quote_dbl_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] start_reg, start_next;
    word_t       word_reg, word_next;

    class_t         word_class;
    slt_pkg::rec_t  word_rec;
    slt_pkg::rec_t  sym_rec;
    slt_pkg::rec_t  unclosed_rec;
    slt_pkg::rec_t  end_rec;
    slt_pkg::rec_t  rec0;
    slt_pkg::rec_t  rec1;
    logic [1:0]     rec_count;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        is_symbol = (c == 8'h28) || (c == 8'h29) || (c == 8'h2A) || (c == 8'h2B)
                 || (c == 8'h2C) || (c == 8'h3B) || (c == 8'h40) || (c == 8'h5B)
                 || (c == 8'h5D) || (c == 8'h7B) || (c == 8'h7D);
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v < slt_pkg::LEN_CAP) ? v + 16'd1 : slt_pkg::LEN_CAP;
    endfunction

    // Appends one byte to the word and updates its keyword and class tracking.
    function automatic word_t push_byte(input word_t w, input logic [7:0] c);
        word_t      r;
        logic [2:0] idx;
        logic       short_word;
        r          = w;
        idx        = w.len[2:0];
        short_word = (w.len < 16'd6);
        if (w.len < 16'd3)
        begin
            unique case (w.len[1:0])
                2'd0:    r.lead[7:0]   = c;
                2'd1:    r.lead[15:8]  = c;
                default: r.lead[23:16] = c;
            endcase
        end
        for (int k = 0; k < 3; k++)
        begin
            if (!(short_word && (3'(w.len) < slt_pkg::KW_LEN[k])
                  && (slt_pkg::KW_CHARS[k][idx] == c)))
            begin
                r.alive[k] = 1'b0;
            end
        end
        if (w.len == 16'd0)
        begin
            r.flags = {c == CH_DOT, is_digit(c) || c == CH_DOT, is_alpha(c) || c == CH_UNDER};
        end
        else
        begin
            if (!(is_alpha(c) || is_digit(c) || c == CH_UNDER))
            begin
                r.flags[0] = 1'b0;
            end
            if (c == CH_DOT)
            begin
                if (w.flags[2])
                begin
                    r.flags[1] = 1'b0;
                end
                r.flags[2] = 1'b1;
            end
            else if (!is_digit(c))
            begin
                r.flags[1] = 1'b0;
            end
        end
        r.len = sat_inc(w.len);
        push_byte = r;
    endfunction

    // Classifies a finished word: keyword, integer type, identifier, number or invalid.
    function automatic class_t classify(input word_t w);
        class_t     r;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       int_lead;
        logic [6:0] value;
        b0       = w.lead[7:0];
        b1       = w.lead[15:8];
        b2       = w.lead[23:16];
        int_lead = (b0 == CH_LOW_S) || (b0 == CH_LOW_U);
        value    = {3'd0, b1[3:0]} * 7'd10 + {3'd0, b2[3:0]};
        r.bits   = 6'd0;
        if (w.flags[0])
        begin
            r.kind = slt_pkg::KIND_IDENT;
        end
        else if (w.flags[1])
        begin
            r.kind = slt_pkg::KIND_NUMBER;
        end
        else
        begin
            r.kind = slt_pkg::KIND_INVALID;
        end
        if (int_lead && w.len == 16'd3 && is_digit(b1) && is_digit(b2)
            && value >= 7'd10 && value <= 7'd32)
        begin
            r.kind = slt_pkg::KIND_INT;
            r.bits = value[5:0];
        end
        if (int_lead && w.len == 16'd2 && b1 >= CH_ONE && b1 <= CH_NINE)
        begin
            r.kind = slt_pkg::KIND_INT;
            r.bits = {2'd0, b1[3:0]};
        end
        // Lower keyword index wins, so walk from the top down.
        for (int k = 2; k >= 0; k--)
        begin
            if (w.alive[k] && w.len == {13'd0, slt_pkg::KW_LEN[k]})
            begin
                r.kind = slt_pkg::KW_KIND[k];
                r.bits = 6'd0;
            end
        end
        classify = r;
    endfunction

    // Candidate records built from the present state.
    always_comb
    begin
        word_class = classify(word_reg);

        word_rec          = '0;
        word_rec.kind     = word_class.kind;
        word_rec.start    = start_reg;
        word_rec.length   = word_reg.len;
        word_rec.bits     = word_class.bits;

        sym_rec           = '0;
        sym_rec.kind      = slt_pkg::KIND_SYMBOL;
        sym_rec.start     = pos_reg;
        sym_rec.length    = 16'd1;

        unclosed_rec          = '0;
        unclosed_rec.kind     = slt_pkg::KIND_INVALID;
        unclosed_rec.start    = start_reg - 32'd1;
        unclosed_rec.length   = sat_inc(word_reg.len);
        unclosed_rec.unclosed = 1'b1;

        end_rec       = '0;
        end_rec.kind  = slt_pkg::KIND_END;
        end_rec.start = pos_reg;
    end

    // Next state and records for one accepted transaction.
    always_comb
    begin
        mode_next      = mode_reg;
        quote_dbl_next = quote_dbl_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        word_next      = word_reg;
        rec0           = '0;
        rec1           = '0;
        rec_count      = 2'd0;

        if (accept && end_of_input)
        begin
            // Flush any pending token, then the end token, then return to reset state.
            if (mode_reg == MODE_SLASH || mode_reg == MODE_WORD)
            begin
                rec0      = word_rec;
                rec1      = end_rec;
                rec_count = 2'd2;
            end
            else if (mode_reg == MODE_STRING)
            begin
                rec0      = unclosed_rec;
                rec1      = end_rec;
                rec_count = 2'd2;
            end
            else
            begin
                rec0      = end_rec;
                rec_count = 2'd1;
            end
            mode_next      = MODE_IDLE;
            quote_dbl_next = 1'b0;
            pos_next       = 32'd0;
            start_next     = 32'd0;
            word_next      = WORD_INIT;
        end
        else if (accept)
        begin
            pos_next = pos_reg + 32'd1;
            unique case (mode_reg)
                MODE_SLASH, MODE_WORD:
                begin
                    if (mode_reg == MODE_SLASH && character == CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (mode_reg == MODE_SLASH && character == CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                    else if (is_space(character))
                    begin
                        rec0      = word_rec;
                        rec_count = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else if (is_symbol(character))
                    begin
                        rec0      = word_rec;
                        rec1      = sym_rec;
                        rec_count = 2'd2;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        word_next = push_byte(word_reg, character);
                        mode_next = MODE_WORD;
                    end
                end
                MODE_LINE:
                begin
                    if (character == CH_LF)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_BLOCK:
                begin
                    if (character == CH_STAR)
                    begin
                        mode_next = MODE_STAR;
                    end
                end
                MODE_STAR:
                begin
                    if (character == CH_SLASH)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (character != CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                end
                MODE_STRING:
                begin
                    if (character == (quote_dbl_reg ? CH_DQUOTE : CH_SQUOTE))
                    begin
                        rec0        = word_rec;
                        rec0.kind   = slt_pkg::KIND_STRING;
                        rec0.bits   = 6'd0;
                        rec_count   = 2'd1;
                        mode_next   = MODE_IDLE;
                    end
                    else
                    begin
                        word_next.len = sat_inc(word_reg.len);
                    end
                end
                default:
                begin
                    // Between tokens.
                    mode_next = MODE_IDLE;
                    if (is_space(character))
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (character == CH_SLASH)
                    begin
                        start_next = pos_reg;
                        word_next  = push_byte(WORD_INIT, character);
                        mode_next  = MODE_SLASH;
                    end
                    else if (is_symbol(character))
                    begin
                        rec0      = sym_rec;
                        rec_count = 2'd1;
                    end
                    else if (character == CH_DQUOTE || character == CH_SQUOTE)
                    begin
                        quote_dbl_next = (character == CH_DQUOTE);
                        start_next     = pos_reg + 32'd1;
                        word_next.len  = 16'd0;
                        mode_next      = MODE_STRING;
                    end
                    else
                    begin
                        start_next = pos_reg;
                        word_next  = push_byte(WORD_INIT, character);
                        mode_next  = MODE_WORD;
                    end
                end
            endcase
        end

        // Mark the final record of this transaction.
        if (rec_count == 2'd1)
        begin
            rec0.last = 1'b1;
        end
        else if (rec_count == 2'd2)
        begin
            rec1.last = 1'b1;
        end

        push.count  = rec_count;
        push.first  = rec0;
        push.second = rec1;
    end

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            quote_dbl_reg <= 1'b0;
            pos_reg       <= 32'd0;
            start_reg     <= 32'd0;
            word_reg      <= WORD_INIT;
        end
        else
        begin
            mode_reg      <= mode_next;
            quote_dbl_reg <= quote_dbl_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            word_reg      <= word_next;
        end
    end

endmodule

/* rtl/slt_queue.sv */
// Three-slot result queue that takes up to two records per cycle and delivers one.
module slt_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  slt_pkg::push_t   push,
    input  logic             ready,
    output logic             valid,
    output slt_pkg::rec_t    head,
    output logic             room
);

    slt_pkg::rec_t  slot_reg  [slt_pkg::QUEUE_DEPTH];
    slt_pkg::rec_t  slot_next [slt_pkg::QUEUE_DEPTH];
    slt_pkg::rec_t  shifted   [slt_pkg::QUEUE_DEPTH];
    logic [1:0]     count_reg, count_next;
    logic [1:0]     count_kept;
    logic           pop;

    assign valid = (count_reg != 2'd0);
    assign head  = slot_reg[0];
    assign pop   = valid && ready;
    // Room is raised only while two slots are free for the next transaction's records.
    assign room  = (count_reg <= 2'd1);

    // Drop the delivered record, then append the new ones behind the survivors.
    always_comb
    begin
        count_kept = count_reg - {1'b0, pop};
        for (int i = 0; i < slt_pkg::QUEUE_DEPTH - 1; i++)
        begin
            if (pop)
            begin
                shifted[i] = slot_reg[i + 1];
            end
            else
            begin
                shifted[i] = slot_reg[i];
            end
        end
        shifted[slt_pkg::QUEUE_DEPTH - 1] = slot_reg[slt_pkg::QUEUE_DEPTH - 1];
        for (int i = 0; i < slt_pkg::QUEUE_DEPTH; i++)
        begin
            slot_next[i] = shifted[i];
            if (push.count != 2'd0 && 2'(i) == count_kept)
            begin
                slot_next[i] = push.first;
            end
            if (push.count == 2'd2 && 2'(i) == count_kept + 2'd1)
            begin
                slot_next[i] = push.second;
            end
        end
        count_next = count_kept + push.count;
    end

    // Occupancy count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Record slots.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < slt_pkg::QUEUE_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    // New records arrive only when there was room for two.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= 2'd1)
        else $error("records pushed into a queue without room");

    // Without delivery the count grows by exactly the records pushed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> count_reg == $past(count_reg) + $past(push.count))
        else $error("queue count lost or invented records");

    // A delivery with nothing new lowers the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count wrong after a delivery");

endmodule

/* rtl/spec_language_tokenizer.sv */
// A record is written into the registered result queue when its source byte is taken.
// Throughput: one byte per cycle while each byte yields at most one record and the sink keeps up.
// A byte that yields two records (word followed by a symbol or end token) holds off the next
// byte until a slot frees, as the three-slot result queue takes bytes only with two slots free.
// Reset clears the scanner to its between-tokens state at offset zero and empties the queue.
module spec_language_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic [0:0]  s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] token_start, [47:32] token_length,
                                        // [53:48] integer_bits, [55:54] zero
    output logic [4:0]  m_axis_tuser,   // [3:0] token_kind, [4] unclosed_string
    output logic        m_axis_tlast    // last_of_run
);

    logic            accept;
    logic            room;
    slt_pkg::push_t  push;
    slt_pkg::rec_t   head;

    // A transaction is taken whenever the queue can hold two more records.
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    // Per-byte scanner.
    slt_scan u_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .character    (s_axis_tdata),
        .end_of_input (s_axis_tuser[0]),
        .push         (push)
    );

    // Result queue toward the master side.
    slt_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .ready (m_axis_tready),
        .valid (m_axis_tvalid),
        .head  (head),
        .room  (room)
    );

    // Output packing.
    assign m_axis_tdata = {2'b00, head.bits, head.length, head.start};
    assign m_axis_tuser = {head.unclosed, head.kind};
    assign m_axis_tlast = head.last;

endmodule

/* dv/slt_token_checker.sv */
// Scoreboard for the tokenizer: tracks the scanner state, predicts token records and checks them.
module slt_token_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic [0:0]  s_axis_tuser,   // [0] end_of_input
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // [31:0] token_start, [47:32] token_length,
                                        // [53:48] integer_bits, [55:54] zero
    input  logic [4:0]  m_axis_tuser,   // [3:0] token_kind, [4] unclosed_string
    input  logic        m_axis_tlast,   // last_of_run
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_SLASH,
        SCAN_WORD,
        SCAN_LINE,
        SCAN_BLOCK,
        SCAN_STAR,
        SCAN_STRING
    } scan_mode_t;

    // Shadow copy of the scanner state.
    scan_mode_t  mode;
    logic        quote_dq;
    logic [31:0] byte_pos;
    logic [31:0] word_start;
    logic [15:0] tok_len;
    logic [23:0] lead;
    logic [2:0]  kw_alive;
    logic [2:0]  wflags;    // [0] identifier still valid, [1] number still valid, [2] dot seen

    // Records caused by the current transaction, and all records still awaited.
    slt_pkg::rec_t step_recs[$];
    slt_pkg::rec_t expected_tokens[$];

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_symbol(logic [7:0] c);
        case (c)
            "(", ")", "*", "+", ",", ";", "@", "[", "]", "{", "}": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [15:0] len_inc(logic [15:0] v);
        return (v < slt_pkg::LEN_CAP) ? v + 16'd1 : slt_pkg::LEN_CAP;
    endfunction

    task clear_scanner();
        mode       = SCAN_IDLE;
        quote_dq   = 1'b0;
        byte_pos   = '0;
        word_start = '0;
        tok_len    = '0;
        lead       = '0;
        kw_alive   = 3'b111;
        wflags     = 3'b011;
    endtask

    task open_word(input logic [31:0] pos);
        word_start = pos;
        tok_len    = '0;
        lead       = '0;
        kw_alive   = 3'b111;
        wflags     = 3'b011;
    endtask

    task add_record(input logic [3:0] kind, input logic [31:0] start, input logic [15:0] len,
                    input logic [5:0] bits, input logic unclosed);
        slt_pkg::rec_t r;
        r.kind     = kind;
        r.start    = start;
        r.length   = len;
        r.bits     = bits;
        r.unclosed = unclosed;
        r.last     = 1'b0;
        step_recs.push_back(r);
    endtask

    // Extend the current word by one byte and narrow down what it can still be.
    task append_word_byte(input logic [7:0] c);
        logic [15:0] idx;
        idx = tok_len;
        if (idx < 16'd3)
            lead[8*int'(idx) +: 8] = c;
        for (int k = 0; k < 3; k++) begin
            if (kw_alive[k]) begin
                if (idx >= 16'(slt_pkg::KW_LEN[k]))
                    kw_alive[k] = 1'b0;
                else if (slt_pkg::KW_CHARS[k][idx[2:0]] != c)
                    kw_alive[k] = 1'b0;
            end
        end
        if (idx == 16'd0) begin
            wflags = {c == ".", is_digit(c) || c == ".", is_alpha(c) || c == "_"};
        end
        else begin
            if (!(is_alpha(c) || is_digit(c) || c == "_"))
                wflags[0] = 1'b0;
            if (c == ".") begin
                if (wflags[2])
                    wflags[1] = 1'b0;
                wflags[2] = 1'b1;
            end
            else if (!is_digit(c)) begin
                wflags[1] = 1'b0;
            end
        end
        tok_len = len_inc(tok_len);
    endtask

    // Classify the finished word and record it.
    task finish_word();
        logic [7:0] b1;
        logic [7:0] b2;
        logic       int_prefix;
        logic       kw_hit;
        logic [3:0] kind;
        logic [5:0] bits;
        int         two_digit;
        b1         = lead[15:8];
        b2         = lead[23:16];
        int_prefix = lead[7:0] == "s" || lead[7:0] == "u";
        two_digit  = (int'(b1) - 48) * 10 + (int'(b2) - 48);
        kw_hit     = 1'b0;
        kind       = slt_pkg::KIND_INVALID;
        bits       = '0;
        for (int k = 0; k < 3; k++) begin
            if (kw_alive[k] && tok_len == 16'(slt_pkg::KW_LEN[k])) begin
                kw_hit = 1'b1;
                kind   = slt_pkg::KW_KIND[k];
            end
        end
        if (!kw_hit) begin
            if (int_prefix && tok_len == 16'd2 && b1 >= "1" && b1 <= "9") begin
                kind = slt_pkg::KIND_INT;
                bits = 6'(int'(b1) - 48);
            end
            else if (int_prefix && tok_len == 16'd3 && is_digit(b1) && is_digit(b2)
                     && two_digit >= 10 && two_digit <= 32) begin
                kind = slt_pkg::KIND_INT;
                bits = 6'(two_digit);
            end
            else if (wflags[0]) begin
                kind = slt_pkg::KIND_IDENT;
            end
            else if (wflags[1]) begin
                kind = slt_pkg::KIND_NUMBER;
            end
        end
        add_record(kind, word_start, tok_len, bits, 1'b0);
    endtask

    // A byte seen inside a word: whitespace and symbols end it.
    task word_byte(input logic [7:0] c, input logic [31:0] pos);
        if (is_space(c)) begin
            finish_word();
            mode = SCAN_IDLE;
        end
        else if (is_symbol(c)) begin
            finish_word();
            add_record(slt_pkg::KIND_SYMBOL, pos, 16'd1, 6'd0, 1'b0);
            mode = SCAN_IDLE;
        end
        else begin
            append_word_byte(c);
        end
    endtask

    // Advance the shadow scanner by one transaction and queue the records it causes.
    task tokenize(input logic [7:0] c, input logic eoi);
        logic [31:0] pos;
        step_recs.delete();
        if (eoi) begin
            if (mode == SCAN_SLASH || mode == SCAN_WORD)
                finish_word();
            else if (mode == SCAN_STRING)
                add_record(slt_pkg::KIND_INVALID, word_start - 32'd1, len_inc(tok_len),
                           6'd0, 1'b1);
            add_record(slt_pkg::KIND_END, byte_pos, 16'd0, 6'd0, 1'b0);
            clear_scanner();
        end
        else begin
            pos      = byte_pos;
            byte_pos = pos + 32'd1;
            case (mode)
                SCAN_SLASH: begin
                    if (c == "/") begin
                        mode = SCAN_LINE;
                    end
                    else if (c == "*") begin
                        mode = SCAN_BLOCK;
                    end
                    else begin
                        mode = SCAN_WORD;
                        word_byte(c, pos);
                    end
                end
                SCAN_WORD: word_byte(c, pos);
                SCAN_LINE: begin
                    if (c == 8'h0A)
                        mode = SCAN_IDLE;
                end
                SCAN_BLOCK: begin
                    if (c == "*")
                        mode = SCAN_STAR;
                end
                SCAN_STAR: begin
                    if (c == "/")
                        mode = SCAN_IDLE;
                    else if (c != "*")
                        mode = SCAN_BLOCK;
                end
                SCAN_STRING: begin
                    if (c == (quote_dq ? 8'h22 : 8'h27)) begin
                        add_record(slt_pkg::KIND_STRING, word_start, tok_len, 6'd0, 1'b0);
                        mode = SCAN_IDLE;
                    end
                    else begin
                        tok_len = len_inc(tok_len);
                    end
                end
                default: begin
                    if (is_space(c)) begin
                        mode = SCAN_IDLE;
                    end
                    else if (c == "/") begin
                        open_word(pos);
                        append_word_byte(c);
                        mode = SCAN_SLASH;
                    end
                    else if (is_symbol(c)) begin
                        add_record(slt_pkg::KIND_SYMBOL, pos, 16'd1, 6'd0, 1'b0);
                        mode = SCAN_IDLE;
                    end
                    else if (c == 8'h22 || c == 8'h27) begin
                        quote_dq   = c == 8'h22;
                        word_start = pos + 32'd1;
                        tok_len    = '0;
                        mode       = SCAN_STRING;
                    end
                    else begin
                        open_word(pos);
                        append_word_byte(c);
                        mode = SCAN_WORD;
                    end
                end
            endcase
        end
        if (step_recs.size() > 0)
            step_recs[step_recs.size() - 1].last = 1'b1;
        foreach (step_recs[i])
            expected_tokens.push_back(step_recs[i]);
    endtask

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("%0d ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Compare one record from the master side with the oldest expected one.
    task check_record();
        slt_pkg::rec_t want;
        if (expected_tokens.size() == 0) begin
            report_mismatch("token record with none expected", 32'(m_axis_tuser[3:0]), 32'd0);
        end
        else begin
            want = expected_tokens.pop_front();
            if (m_axis_tuser[3:0] != want.kind)
                report_mismatch("token_kind", 32'(m_axis_tuser[3:0]), 32'(want.kind));
            if (m_axis_tdata[31:0] != want.start)
                report_mismatch("token_start", m_axis_tdata[31:0], want.start);
            if (m_axis_tdata[47:32] != want.length)
                report_mismatch("token_length", 32'(m_axis_tdata[47:32]), 32'(want.length));
            if (m_axis_tdata[53:48] != want.bits)
                report_mismatch("integer_bits", 32'(m_axis_tdata[53:48]), 32'(want.bits));
            if (m_axis_tuser[4] != want.unclosed)
                report_mismatch("unclosed_string", 32'(m_axis_tuser[4]), 32'(want.unclosed));
            if (m_axis_tlast != want.last)
                report_mismatch("last_of_run", 32'(m_axis_tlast), 32'(want.last));
        end
    endtask

    // Input transactions are predicted first, then any output transaction is checked.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_scanner();
            expected_tokens.delete();
            mismatches = 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready)
                tokenize(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready)
                check_record();
        end
        outstanding = expected_tokens.size();
    end

endmodule

/* dv/tb_top.sv */
// Testbench top for the tokenizer: clock, reset, byte stimulus, sink pacing and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] character
    logic [0:0]  s_axis_tuser;     // [0] end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;     // [31:0] token_start, [47:32] token_length,
                                   // [53:48] integer_bits, [55:54] zero
    logic [4:0]  m_axis_tuser;     // [3:0] token_kind, [4] unclosed_string
    logic        m_axis_tlast;     // last_of_run

    int          mismatches;
    int          outstanding;
    int          items_sent;
    logic [7:0]  text_q[$];
    int          burst_left[2];
    bit          calm[2];

    localparam int SIDE_TX = 0;
    localparam int SIDE_RX = 1;

    string kw_words[3] = '{"enum", "flags", "struct"};

    spec_language_tokenizer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    slt_token_checker token_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Clock generation.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Per-transaction idle cycles, drawn in random bursts that are either calm or busy.
    function int draw_gap(int side);
        if (burst_left[side] == 0) begin
            burst_left[side] = $urandom_range(8, 40);
            calm[side]       = $urandom_range(0, 2) == 0;
        end
        burst_left[side]--;
        return calm[side] ? 0 : $urandom_range(0, 7);
    endfunction

    function logic [7:0] pick_from(string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    task push_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // Offer one input transaction after the given idle cycles and wait until it is taken.
    task send_item(input logic [7:0] c, input logic eoi, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= eoi;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task send_text();
        foreach (text_q[i])
            send_item(text_q[i], 1'b0, draw_gap(SIDE_TX));
        text_q.delete();
    endtask

    // Build one random phrase of source text; mostly well-formed tokens with random content.
    task make_phrase(output bit want_eoi);
        int n;
        want_eoi = 1'b0;
        case ($urandom_range(0, 12))
            0: begin
                push_text(kw_words[$urandom_range(0, 2)]);
                n = $urandom_range(0, 5);
                if (n == 0)
                    text_q.push_back("s");
                else if (n == 1)
                    void'(text_q.pop_back());
            end
            1: begin
                text_q.push_back($urandom_range(0, 1) ? "s" : "u");
                n = $urandom_range(0, 40);
                case ($urandom_range(0, 2))
                    0: text_q.push_back(8'("0" + $urandom_range(0, 9)));
                    1: begin
                        text_q.push_back(8'("0" + n / 10));
                        text_q.push_back(8'("0" + n % 10));
                    end
                    default: begin
                        text_q.push_back(8'("0" + n / 10));
                        text_q.push_back(8'("0" + n % 10));
                        text_q.push_back(pick_from("0123456789a_."));
                    end
                endcase
            end
            2: begin
                text_q.push_back(pick_from("abcxyzABZ_"));
                repeat ($urandom_range(0, 8))
                    text_q.push_back(pick_from("abcdefqrsuzAMZ0123456789_"));
            end
            3: begin
                repeat ($urandom_range(1, 6))
                    text_q.push_back(pick_from("0123456789012345."));
            end
            4: begin
                n = $urandom_range(0, 1) ? 8'h22 : 8'h27;
                text_q.push_back(8'(n));
                repeat ($urandom_range(0, 6))
                    text_q.push_back(pick_from("ab x\t*/;'"));
                text_q.push_back(8'(n));
            end
            5: begin
                push_text("//");
                repeat ($urandom_range(0, 6))
                    text_q.push_back(pick_from("ab */;\"'"));
                text_q.push_back(8'h0A);
            end
            6: begin
                push_text("/*");
                repeat ($urandom_range(0, 6))
                    text_q.push_back(pick_from("ab *\n;/"));
                push_text($urandom_range(0, 1) ? "*/" : "**/");
            end
            7: text_q.push_back(pick_from("()*+,;@[]{}"));
            8: begin
                text_q.push_back("/");
                if ($urandom_range(0, 1))
                    text_q.push_back(pick_from("ax1.'/"));
            end
            9: begin
                text_q.push_back(pick_from("abs1"));
                text_q.push_back($urandom_range(0, 1) ? 8'h22 : 8'h27);
                text_q.push_back(pick_from("cd2"));
            end
            10: begin
                repeat ($urandom_range(1, 5))
                    text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            11: begin
                // Open a string or a comment and let the end of input cut it off.
                case ($urandom_range(0, 2))
                    0: text_q.push_back(8'h22);
                    1: text_q.push_back(8'h27);
                    default: push_text("/*");
                endcase
                repeat ($urandom_range(0, 4))
                    text_q.push_back(pick_from("ab *x"));
                want_eoi = 1'b1;
            end
            default: begin
                repeat ($urandom_range(1, 3))
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        // Separator after the phrase.
        case ($urandom_range(0, 5))
            0: ;
            4: text_q.push_back(pick_from("()*+,;@[]{}"));
            default: text_q.push_back(pick_from(" \t\n\013\014\015"));
        endcase
        if ($urandom_range(0, 19) == 0)
            want_eoi = 1'b1;
    endtask

    // Sink pacing, with two long hold-offs so the input side backs up.
    initial begin
        int hold;
        int taken;
        taken = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (taken == 40 || taken == 120)
                hold = 150;
            else
                hold = draw_gap(SIDE_RX);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    // Stimulus and verdict.
    initial begin
        int base;
        bit want_eoi;
        items_sent    = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keyword ended by a symbol, an int type, a lone slash at end of input,
        // an unclosed string holding byte 0xFF, an unclosed block comment holding byte 0x00.
        push_text("struct( u32 /");
        send_text();
        send_item(8'hFF, 1'b1, draw_gap(SIDE_TX));
        push_text("'ab");
        text_q.push_back(8'hFF);
        send_text();
        send_item(8'h00, 1'b1, draw_gap(SIDE_TX));
        push_text("/*");
        text_q.push_back(8'h00);
        send_text();
        send_item(8'h5A, 1'b1, draw_gap(SIDE_TX));

        // Random phrases.
        base = items_sent;
        while (items_sent - base < 550) begin
            make_phrase(want_eoi);
            send_text();
            if (want_eoi)
                send_item(8'($urandom_range(0, 255)), 1'b1, draw_gap(SIDE_TX));
        end
        send_item(8'($urandom_range(0, 255)), 1'b1, draw_gap(SIDE_TX));
        s_axis_tvalid <= 1'b0;

        // Drain the expected records, then allow for the pipeline latency.
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/slt_pkg.sv
rtl/slt_scan.sv
rtl/slt_queue.sv
rtl/spec_language_tokenizer.sv
dv/slt_token_checker.sv
dv/tb_top.sv
